// File: rtl/dms_pkg.sv
// ----------------------------------------------------------------------------
// dms_pkg: shared types and constants of the multiplicity sum unit
// Holds the item kinds, register indexes, controller states and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package dms_pkg;

    localparam int unsigned WF_SAMPLES_DEF = 1024;

    localparam int unsigned KIND_W      = 2;
    localparam int unsigned CHAN_ID_W   = 7;
    localparam int unsigned CHAN_TYPE_W = 3;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned RD_IDX_W    = 10;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 10;

    typedef enum logic [KIND_W-1:0] {
        KIND_PULSE = 2'd0,
        KIND_EOC   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DESIRED_CHANNEL = 3'd0,
        CFG_WANTED_TYPE     = 3'd1,
        CFG_LOGIC_WIDTH     = 3'd2,
        CFG_PRE_SAMPLES     = 3'd3,
        CFG_POST_SAMPLES    = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECODE,
        ST_PSUM,
        ST_PCHK,
        ST_FILL,
        ST_ADD,
        ST_SCLR,
        ST_RDWAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic pre;
        logic psum;
        logic pchk;
        logic addr_clr;
        logic addr_load;
        logic addr_inc;
        logic init_wr;
        logic fill_wr;
        logic add_rd;
        logic sclr_wr;
        logic rd_cap;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  match;
        logic  oor;
        logic  empty;
        logic  addr_last;
        logic  fill_last;
    } t_dp_status;

endpackage

// File: rtl/dms_in_if.sv
// ----------------------------------------------------------------------------
// dms_in_if: input item channel
// Valid/ready channel carrying one pulse, end-of-channel, read or clear item.
// ----------------------------------------------------------------------------
interface dms_in_if;
    logic                              valid;
    logic                              ready;
    logic [dms_pkg::KIND_W-1:0]        kind;
    logic [dms_pkg::CHAN_ID_W-1:0]     chan_id;
    logic signed [dms_pkg::CHAN_TYPE_W-1:0] chan_type;
    logic [dms_pkg::SAMPLE_W-1:0]      pulse_start;
    logic [dms_pkg::SAMPLE_W-1:0]      pulse_len;
    logic [dms_pkg::RD_IDX_W-1:0]      read_index;

    modport source (output valid, kind, chan_id, chan_type, pulse_start,
                    pulse_len, read_index, input ready);
    modport sink   (input valid, kind, chan_id, chan_type, pulse_start,
                    pulse_len, read_index, output ready);
endinterface

// File: rtl/dms_out_if.sv
// ----------------------------------------------------------------------------
// dms_out_if: result channel
// Valid/ready channel carrying the status and count of one result.
// ----------------------------------------------------------------------------
interface dms_out_if;
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [dms_pkg::COUNT_W-1:0]  count;

    modport source (output valid, status, count, input ready);
    modport sink   (input valid, status, count, output ready);
endinterface

// File: rtl/dms_ctrl.sv
// ----------------------------------------------------------------------------
// dms_ctrl: sequencing state machine
// Steps each item through decode, window fill, bitmap add, store clear or
// store read, and hands finished results to the output register.
// ----------------------------------------------------------------------------
module dms_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dms_pkg::t_dp_status i_status,
    output dms_pkg::t_dp_cmd    o_cmd
);

    dms_pkg::t_state r_state, n_state;
    logic            r_out_valid;
    logic            out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == dms_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dms_pkg::ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dms_pkg::ST_INIT: begin
                if (i_status.addr_last) n_state = dms_pkg::ST_IDLE;
            end
            dms_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = dms_pkg::ST_DECODE;
            end
            dms_pkg::ST_DECODE: begin
                case (i_status.kind)
                    dms_pkg::KIND_PULSE: n_state = dms_pkg::ST_PSUM;
                    dms_pkg::KIND_EOC:   n_state = dms_pkg::ST_ADD;
                    dms_pkg::KIND_READ:  n_state = dms_pkg::ST_RDWAIT;
                    default:             n_state = dms_pkg::ST_SCLR;
                endcase
            end
            dms_pkg::ST_PSUM: n_state = dms_pkg::ST_PCHK;
            dms_pkg::ST_PCHK: begin
                if (!i_status.match || i_status.oor || i_status.empty) begin
                    n_state = dms_pkg::ST_DONE;
                end else begin
                    n_state = dms_pkg::ST_FILL;
                end
            end
            dms_pkg::ST_FILL: begin
                if (i_status.fill_last) n_state = dms_pkg::ST_DONE;
            end
            dms_pkg::ST_ADD, dms_pkg::ST_SCLR: begin
                if (i_status.addr_last) n_state = dms_pkg::ST_DONE;
            end
            dms_pkg::ST_RDWAIT: n_state = dms_pkg::ST_DONE;
            dms_pkg::ST_DONE: begin
                if (out_free) n_state = dms_pkg::ST_IDLE;
            end
            default: n_state = dms_pkg::ST_INIT;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            dms_pkg::ST_INIT: begin
                o_cmd.init_wr  = 1'b1;
                o_cmd.addr_clr = i_status.addr_last;
                o_cmd.addr_inc = !i_status.addr_last;
            end
            dms_pkg::ST_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            dms_pkg::ST_DECODE: begin
                o_cmd.pre = 1'b1;
            end
            dms_pkg::ST_PSUM: begin
                o_cmd.psum = 1'b1;
            end
            dms_pkg::ST_PCHK: begin
                o_cmd.pchk      = 1'b1;
                o_cmd.addr_load = i_status.match && !i_status.oor && !i_status.empty;
            end
            dms_pkg::ST_FILL: begin
                o_cmd.fill_wr  = 1'b1;
                o_cmd.addr_inc = !i_status.fill_last;
            end
            dms_pkg::ST_ADD: begin
                o_cmd.add_rd   = 1'b1;
                o_cmd.addr_inc = !i_status.addr_last;
            end
            dms_pkg::ST_SCLR: begin
                o_cmd.sclr_wr  = 1'b1;
                o_cmd.addr_inc = !i_status.addr_last;
            end
            dms_pkg::ST_RDWAIT: begin
                o_cmd.rd_cap = 1'b1;
            end
            dms_pkg::ST_DONE: begin
                o_cmd.addr_clr = 1'b1;
                o_cmd.push     = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/dms_datapath.sv
// ----------------------------------------------------------------------------
// dms_datapath: registers, window arithmetic and the two sample memories
// Holds the configuration, the latched item, the address counter, the
// channel bitmap and multiplicity store memories and the result registers.
// ----------------------------------------------------------------------------
module dms_datapath #(
    parameter int unsigned WF_SAMPLES = dms_pkg::WF_SAMPLES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [dms_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [dms_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic [dms_pkg::KIND_W-1:0]             i_kind,
    input  logic [dms_pkg::CHAN_ID_W-1:0]          i_chan_id,
    input  logic signed [dms_pkg::CHAN_TYPE_W-1:0] i_chan_type,
    input  logic [dms_pkg::SAMPLE_W-1:0]           i_pulse_start,
    input  logic [dms_pkg::SAMPLE_W-1:0]           i_pulse_len,
    input  logic [dms_pkg::RD_IDX_W-1:0]           i_read_index,
    input  dms_pkg::t_dp_cmd                       i_cmd,
    output dms_pkg::t_dp_status                    o_status,
    output logic                                   o_res_status,
    output logic [dms_pkg::COUNT_W-1:0]            o_res_count
);

    localparam int unsigned AW = (WF_SAMPLES > 1) ? $clog2(WF_SAMPLES) : 1;
    localparam int unsigned IW = (AW > dms_pkg::RD_IDX_W) ? AW : dms_pkg::RD_IDX_W;
    localparam logic [17:0]   WF_L    = 18'(WF_SAMPLES);
    localparam logic [17:0]   LAST_L  = 18'(WF_SAMPLES - 1);
    localparam logic [AW-1:0] LAST_A  = AW'(WF_SAMPLES - 1);
    localparam logic [dms_pkg::COUNT_W-1:0] CNT_MAX = '1;

    // Configuration registers.
    logic signed [7:0] r_desired;
    logic signed [2:0] r_wanted;
    logic [9:0]        r_lw;
    logic [7:0]        r_pre;
    logic [7:0]        r_post;

    // Latched item.
    dms_pkg::t_kind                       r_kind;
    logic [dms_pkg::CHAN_ID_W-1:0]        r_id;
    logic [dms_pkg::CHAN_TYPE_W-1:0]      r_type;
    logic [dms_pkg::SAMPLE_W-1:0]         r_start;
    logic [dms_pkg::SAMPLE_W-1:0]         r_size;
    logic [dms_pkg::RD_IDX_W-1:0]         r_rdidx;

    // Window arithmetic.
    logic [16:0]        r_s;
    logic signed [17:0] r_w;
    logic [17:0]        r_e;
    logic               r_match;
    logic [AW-1:0]      r_end;
    logic [AW-1:0]      r_addr;

    logic               w_gt;
    logic [17:0]        e_cl;
    logic               oor;
    logic               empty;

    // Memories and their ports.
    logic                        r_bm_mem    [WF_SAMPLES];
    logic [dms_pkg::COUNT_W-1:0] r_store_mem [WF_SAMPLES];
    logic                        r_bm_rdata;
    logic [dms_pkg::COUNT_W-1:0] r_store_rdata;
    logic                        r_add_pend;
    logic [AW-1:0]               r_add_addr;

    logic [IW-1:0]               rd_ext;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic                        bm_we;
    logic                        bm_wdata;
    logic                        st_we;
    logic [dms_pkg::COUNT_W-1:0] st_wdata;
    logic                        rd_in_range;

    logic                        r_res_status;
    logic [dms_pkg::COUNT_W-1:0] r_res_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desired <= 8'sh ff;
            r_wanted  <= 3'sd1;
            r_lw      <= 10'd8;
            r_pre     <= 8'd0;
            r_post    <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dms_pkg::CFG_DESIRED_CHANNEL: r_desired <= i_cfg_data[7:0];
                dms_pkg::CFG_WANTED_TYPE:     r_wanted  <= i_cfg_data[2:0];
                dms_pkg::CFG_LOGIC_WIDTH:     r_lw      <= i_cfg_data[9:0];
                dms_pkg::CFG_PRE_SAMPLES:     r_pre     <= i_cfg_data[7:0];
                dms_pkg::CFG_POST_SAMPLES:    r_post    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind  <= dms_pkg::t_kind'(i_kind);
            r_id    <= i_chan_id;
            r_type  <= i_chan_type;
            r_start <= i_pulse_start;
            r_size  <= i_pulse_len;
            r_rdidx <= i_read_index;
        end
        if (i_cmd.pre) begin
            r_s     <= 17'(r_start) + 17'(r_post);
            r_w     <= $signed({2'b00, r_size}) - $signed({10'd0, r_pre})
                     - $signed({10'd0, r_post});
            r_match <= ((r_desired == -8'sd1) || ({1'b0, r_id} == r_desired))
                     && (r_type == r_wanted);
        end
        if (i_cmd.psum) begin
            r_e <= 18'(r_s) + 18'(r_lw) + (w_gt ? 18'(r_w[16:0]) : 18'd0);
        end
        if (i_cmd.pchk) begin
            r_end <= e_cl[AW-1:0];
        end
    end

    // The window only grows by the pulse width less the pre and post samples when that exceeds the logic width.
    assign w_gt  = r_w > $signed({8'd0, r_lw});
    assign oor   = 18'(r_s) >= WF_L;
    assign e_cl  = (r_e >= WF_L) ? LAST_L : r_e;
    assign empty = e_cl <= 18'(r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_add_pend <= 1'b0;
        end else begin
            r_add_pend <= i_cmd.add_rd;
            if (i_cmd.addr_clr) begin
                r_addr <= '0;
            end else if (i_cmd.addr_load) begin
                r_addr <= r_s[AW-1:0];
            end else if (i_cmd.addr_inc) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_add_addr <= r_addr;
    end

    // Read at the sweep address during an add, otherwise at the read index.
    assign rd_ext      = IW'(r_rdidx);
    assign rd_addr     = i_cmd.add_rd ? r_addr : rd_ext[AW-1:0];
    assign rd_in_range = 18'(r_rdidx) < WF_L;

    // The add writes back in the cycle after its read, at the delayed address.
    assign wr_addr  = r_add_pend ? r_add_addr : r_addr;
    assign bm_we    = i_cmd.init_wr || i_cmd.fill_wr || r_add_pend;
    assign bm_wdata = i_cmd.fill_wr;
    assign st_we    = i_cmd.init_wr || i_cmd.sclr_wr || r_add_pend;
    assign st_wdata = !r_add_pend ? '0 :
                      (r_bm_rdata && (r_store_rdata != CNT_MAX)) ?
                      r_store_rdata + 1'b1 : r_store_rdata;

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bm_mem[wr_addr] <= bm_wdata;
        end
        r_bm_rdata <= r_bm_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store_mem[wr_addr] <= st_wdata;
        end
        r_store_rdata <= r_store_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pre) begin
            r_res_status <= 1'b0;
            r_res_count  <= '0;
        end else if (i_cmd.pchk) begin
            r_res_status <= r_match && oor;
        end else if (i_cmd.rd_cap) begin
            r_res_count <= rd_in_range ? r_store_rdata : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_res_status <= r_res_status;
            o_res_count  <= r_res_count;
        end
    end

    assign o_status.kind      = r_kind;
    assign o_status.match     = r_match;
    assign o_status.oor       = oor;
    assign o_status.empty     = empty;
    assign o_status.addr_last = (r_addr == LAST_A);
    assign o_status.fill_last = (r_addr == (r_end - 1'b1));

endmodule

// File: rtl/discriminator_multiplicity_sum_unit.sv
// ----------------------------------------------------------------------------
// discriminator_multiplicity_sum_unit: discriminator windows and multiplicity
// Stretches pulse records into per-sample logic windows of one channel and
// sums the channel windows into a per-sample multiplicity store.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_item, one transfer per item. A pulse item opens
// a window in the channel bitmap when its channel and type match the
// configuration; an end-of-channel item adds the bitmap into the store and
// clears it; a read item returns one store entry; a clear item zeroes the
// store. Every item yields exactly one result transfer on o_result.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data while
// the block is idle.
// A pulse passes decode, the window sum and the window check, then fills the
// window samples it sets; a rejected, empty or out-of-range pulse skips the
// fill; a read captures one store entry; end-of-channel and store clear walk
// all WF_SAMPLES entries. The window fill and the bitmap add walk the sample
// memories one entry per cycle; items are worked one at a time, and the next
// item is taken once the block is back in idle, when the result turns valid.
// After reset both memories are swept to zero, and i_item.ready stays low
// while they are. A finished result waits in the output
// register while the receiver stalls, and the next item is still accepted;
// it only holds in its last step until the output register is free.
// ----------------------------------------------------------------------------
module discriminator_multiplicity_sum_unit #(
    parameter int unsigned WF_SAMPLES = dms_pkg::WF_SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    dms_in_if.sink                         i_item,
    dms_out_if.source                      o_result,
    input  logic                           i_cfg_we,
    input  logic [dms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dms_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Commands from the controller and flags back from the datapath.
    dms_pkg::t_dp_cmd    cmd;
    dms_pkg::t_dp_status status;

    dms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // The datapath latches the item on the accepting edge and holds the
    // result payload in the output register until the receiver takes it.
    dms_datapath #(
        .WF_SAMPLES (WF_SAMPLES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_item.kind),
        .i_chan_id      (i_item.chan_id),
        .i_chan_type    (i_item.chan_type),
        .i_pulse_start  (i_item.pulse_start),
        .i_pulse_len    (i_item.pulse_len),
        .i_read_index   (i_item.read_index),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_res_status   (o_result.status),
        .o_res_count    (o_result.count)
    );

endmodule
